FILE: hdl/pvadc_pkg.sv
//------------------------------------------------------------------------------
// pvadc_pkg
// Shared widths, codes and handshake structures of the process alarm checker.
//------------------------------------------------------------------------------
`default_nettype none

package pvadc_pkg;

   localparam int NUM_SLOTS     = 8;
   localparam int SLOT_W        = 7;
   localparam int DATA_W        = 32;
   localparam int PCT_W         = 15;
   localparam int MODES_W       = NUM_SLOTS * SLOT_W;
   localparam int TRIP_REG_W    = 64;
   localparam int NUM_TRIP_REGS = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int PRIO_W        = 4;
   localparam int SEV_W         = 5;
   localparam int SPAN_W        = DATA_W + 1;
   localparam int PROD_W        = SPAN_W + PCT_W;
   localparam int PCT_SHIFT     = 8;
   localparam int DIV_BITS      = PROD_W - 1 - PCT_SHIFT;
   localparam int DIVISOR       = 100;
   localparam int REM_W         = 7;
   localparam int DIGIT_W       = 8;
   localparam int NUM_DIGITS    = (DIV_BITS + DIGIT_W - 1) / DIGIT_W;
   localparam int NUM_W         = NUM_DIGITS * DIGIT_W;
   localparam int TRIAL_W       = REM_W + DIGIT_W;
   localparam int RECIP_SHIFT   = 19;
   localparam int RECIP_MUL     = (1 << RECIP_SHIFT) / DIVISOR + 1;
   localparam int RECIP_W       = 13;
   localparam int RECIP_PROD_W  = TRIAL_W + RECIP_W;
   localparam int QUOT_W        = 33;
   localparam int DELTA_W       = QUOT_W + 1;
   localparam int THR_W         = DELTA_W + 1;
   localparam int CNT_W         = 6;

   typedef enum logic [2:0] {
      SLOT_NONE      = 3'd0,
      SLOT_HIGH      = 3'd1,
      SLOT_HIGH_HIGH = 3'd2,
      SLOT_LOW       = 3'd3,
      SLOT_LOW_LOW   = 3'd4
   } slot_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_LOW  = 3'd0,
      CSR_RANGE_HIGH = 3'd1,
      CSR_DEADBAND   = 3'd2,
      CSR_SLOT_MODES = 3'd3,
      CSR_TRIPS_0_1  = 3'd4,
      CSR_TRIPS_2_3  = 3'd5,
      CSR_TRIPS_4_5  = 3'd6,
      CSR_TRIPS_6_7  = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_SIGN,
      ST_THR,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic mul;
      logic load;
      logic div_step;
      logic sign;
      logic thr;
      logic accept;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage : pvadc_pkg

`default_nettype wire

FILE: hdl/pv_alarm_deadband_checker.sv
//------------------------------------------------------------------------------
// pv_alarm_deadband_checker
// Process-value alarm checker: range clamping and eight hysteresis alarm slots.
//------------------------------------------------------------------------------
// A result is registered on the clock edge at which its sample beat is accepted.
// Throughput: one sample per cycle once the deadband thresholds are ready and rsp_stall is low.
// After reset and after every configuration write, the deadband and thresholds are
// recomputed (multiply, load, 5 byte steps of a divide by 100 through a reciprocal
// multiply, sign and threshold update), during which req_stall is held high.
// Reset clears all slot latches and loads the register reset values.
`default_nettype none

module pv_alarm_deadband_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [pvadc_pkg::DATA_W-1:0] req_pv_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [pvadc_pkg::DATA_W-1:0]      rsp_pv_clamped,
   output logic [pvadc_pkg::SEV_W-1:0]              rsp_severity,
   output logic [pvadc_pkg::NUM_SLOTS-1:0]          rsp_active_mask,
   output logic [pvadc_pkg::NUM_SLOTS-1:0]          rsp_raised_mask,
   output logic [pvadc_pkg::NUM_SLOTS-1:0]          rsp_cleared_mask,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pvadc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pvadc_pkg::TRIP_REG_W-1:0]    csr_wdata
);

   pvadc_pkg::ctrl_cmd_type  cmd;
   pvadc_pkg::dp_status_type status;
   logic                     csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   pvadc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pvadc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .req_pv_sample    (req_pv_sample),
      .rsp_pv_clamped   (rsp_pv_clamped),
      .rsp_severity     (rsp_severity),
      .rsp_active_mask  (rsp_active_mask),
      .rsp_raised_mask  (rsp_raised_mask),
      .rsp_cleared_mask (rsp_cleared_mask)
   );

endmodule : pv_alarm_deadband_checker

`default_nettype wire

FILE: hdl/pvadc_ctrl.sv
//------------------------------------------------------------------------------
// pvadc_ctrl
// Sequencer for the deadband calculation and the sample handshake.
//------------------------------------------------------------------------------
`default_nettype none

module pvadc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire pvadc_pkg::dp_status_type status,
   output pvadc_pkg::ctrl_cmd_type      cmd
);

   pvadc_pkg::ctrl_state_type state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      can_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pvadc_pkg::ST_MUL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      can_take     = (state_ff == pvadc_pkg::ST_RUN) && (!rsp_valid_ff || !rsp_stall);
      req_stall    = !can_take;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         pvadc_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = pvadc_pkg::ST_LOAD;
         end
         pvadc_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = pvadc_pkg::ST_DIV;
         end
         pvadc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = pvadc_pkg::ST_SIGN;
            end
         end
         pvadc_pkg::ST_SIGN: begin
            cmd.sign = 1'b1;
            state_in = pvadc_pkg::ST_THR;
         end
         pvadc_pkg::ST_THR: begin
            cmd.thr  = 1'b1;
            state_in = pvadc_pkg::ST_RUN;
         end
         pvadc_pkg::ST_RUN: begin
            if (req_valid && can_take) begin
               cmd.accept   = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = pvadc_pkg::ST_MUL;
         end
      endcase
      if (csr_write) begin
         state_in = pvadc_pkg::ST_MUL;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : pvadc_ctrl

`default_nettype wire

FILE: hdl/pvadc_dp.sv
//------------------------------------------------------------------------------
// pvadc_dp
// Configuration registers, deadband divider, thresholds and slot evaluation.
//------------------------------------------------------------------------------
`default_nettype none

module pvadc_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write,
   input  wire logic [pvadc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [pvadc_pkg::TRIP_REG_W-1:0]       csr_wdata,
   input  wire pvadc_pkg::ctrl_cmd_type                cmd,
   output pvadc_pkg::dp_status_type                    status,
   input  wire logic signed [pvadc_pkg::DATA_W-1:0]    req_pv_sample,
   output logic signed [pvadc_pkg::DATA_W-1:0]         rsp_pv_clamped,
   output logic [pvadc_pkg::SEV_W-1:0]                 rsp_severity,
   output logic [pvadc_pkg::NUM_SLOTS-1:0]             rsp_active_mask,
   output logic [pvadc_pkg::NUM_SLOTS-1:0]             rsp_raised_mask,
   output logic [pvadc_pkg::NUM_SLOTS-1:0]             rsp_cleared_mask
);

   localparam int DW = pvadc_pkg::DATA_W;
   localparam int NS = pvadc_pkg::NUM_SLOTS;
   localparam int TW = pvadc_pkg::THR_W;

   logic signed [DW-1:0]                     range_low_ff, range_high_ff;
   logic [pvadc_pkg::PCT_W-1:0]              pct_ff;
   logic [pvadc_pkg::MODES_W-1:0]            modes_ff;
   logic [pvadc_pkg::TRIP_REG_W-1:0]         trips_ff [pvadc_pkg::NUM_TRIP_REGS];

   logic signed [pvadc_pkg::SPAN_W-1:0]      span;
   logic signed [pvadc_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [pvadc_pkg::PROD_W-1:0]             prod_mag;
   logic                                     neg_ff;
   logic [pvadc_pkg::NUM_W-1:0]              num_ff;
   logic [pvadc_pkg::REM_W-1:0]              rem_ff;
   logic [pvadc_pkg::CNT_W-1:0]              cnt_ff;
   logic [pvadc_pkg::TRIAL_W-1:0]            trial;
   logic [pvadc_pkg::RECIP_PROD_W-1:0]       recip_prod;
   logic [pvadc_pkg::DIGIT_W-1:0]            quot_digit;
   logic [pvadc_pkg::TRIAL_W-1:0]            digit_times_div;
   logic [pvadc_pkg::DELTA_W-1:0]            quot_ext;
   logic signed [pvadc_pkg::DELTA_W-1:0]     delta_ff;
   logic signed [TW-1:0]                     delta_ext;
   logic signed [TW-1:0]                     thr_ff   [NS];
   logic signed [TW-1:0]                     trip_ext [NS];
   logic                                     clamp_en_ff;

   logic [NS-1:0]                            latched_ff, latched_in;
   logic signed [DW-1:0]                     pv_clamped;
   logic signed [TW-1:0]                     pv_ext;
   logic [NS-1:0]                            now_on, slot_used;
   logic [NS-1:0]                            active, raised, cleared;
   logic [pvadc_pkg::SEV_W-1:0]              sev;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= DW'(6553600);
         pct_ff        <= '0;
         modes_ff      <= '0;
         for (int k = 0; k < pvadc_pkg::NUM_TRIP_REGS; k++) begin
            trips_ff[k] <= '0;
         end
      end else if (csr_write) begin
         case (pvadc_pkg::csr_index_type'(csr_index))
            pvadc_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_wdata[DW-1:0];
            pvadc_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_wdata[DW-1:0];
            pvadc_pkg::CSR_DEADBAND:   pct_ff        <= csr_wdata[pvadc_pkg::PCT_W-1:0];
            pvadc_pkg::CSR_SLOT_MODES: modes_ff      <= csr_wdata[pvadc_pkg::MODES_W-1:0];
            pvadc_pkg::CSR_TRIPS_0_1:  trips_ff[0]   <= csr_wdata;
            pvadc_pkg::CSR_TRIPS_2_3:  trips_ff[1]   <= csr_wdata;
            pvadc_pkg::CSR_TRIPS_4_5:  trips_ff[2]   <= csr_wdata;
            pvadc_pkg::CSR_TRIPS_6_7:  trips_ff[3]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Deadband: span times percent, then magnitude divided by 256 and by 100.
   assign span    = {range_high_ff[DW-1], range_high_ff} - {range_low_ff[DW-1], range_low_ff};
   assign prod_in = span * $signed({1'b0, pct_ff});
   assign prod_mag = prod_ff[pvadc_pkg::PROD_W-1] ? (~prod_ff + 1'b1) : prod_ff;

   // One byte of the dividend per step; the quotient digit comes from a reciprocal multiply.
   assign trial           = {rem_ff, num_ff[pvadc_pkg::NUM_W-1 -: pvadc_pkg::DIGIT_W]};
   assign recip_prod      = pvadc_pkg::RECIP_PROD_W'(trial)
                            * pvadc_pkg::RECIP_PROD_W'(pvadc_pkg::RECIP_MUL);
   assign quot_digit      = recip_prod[pvadc_pkg::RECIP_SHIFT +: pvadc_pkg::DIGIT_W];
   assign digit_times_div = pvadc_pkg::TRIAL_W'(quot_digit)
                            * pvadc_pkg::TRIAL_W'(pvadc_pkg::DIVISOR);
   assign quot_ext = {1'b0, num_ff[pvadc_pkg::QUOT_W-1:0]};
   assign delta_ext = {delta_ff[pvadc_pkg::DELTA_W-1], delta_ff};
   assign status.div_done = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.load) begin
         neg_ff <= prod_ff[pvadc_pkg::PROD_W-1];
         num_ff <= pvadc_pkg::NUM_W'(prod_mag[pvadc_pkg::PROD_W-2:pvadc_pkg::PCT_SHIFT]);
         rem_ff <= '0;
         cnt_ff <= pvadc_pkg::CNT_W'(pvadc_pkg::NUM_DIGITS - 1);
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[pvadc_pkg::NUM_W-pvadc_pkg::DIGIT_W-1:0], quot_digit};
         rem_ff <= pvadc_pkg::REM_W'(trial - digit_times_div);
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.sign) begin
         delta_ff <= neg_ff ? $signed(~quot_ext + 1'b1) : $signed(quot_ext);
      end
      if (cmd.thr) begin
         clamp_en_ff <= range_high_ff > range_low_ff;
         for (int k = 0; k < NS; k++) begin
            if (modes_ff[k*pvadc_pkg::SLOT_W +: 3] == pvadc_pkg::SLOT_LOW ||
                modes_ff[k*pvadc_pkg::SLOT_W +: 3] == pvadc_pkg::SLOT_LOW_LOW) begin
               thr_ff[k] <= trip_ext[k] + delta_ext;
            end else begin
               thr_ff[k] <= trip_ext[k] - delta_ext;
            end
         end
      end
   end

   // Per-sample evaluation.
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         trip_ext[k] = TW'($signed(trips_ff[k/2][(k%2)*DW +: DW]));
      end
      pv_clamped = req_pv_sample;
      if (clamp_en_ff) begin
         if (req_pv_sample > range_high_ff) begin
            pv_clamped = range_high_ff;
         end else if (req_pv_sample < range_low_ff) begin
            pv_clamped = range_low_ff;
         end
      end
      pv_ext     = TW'(pv_clamped);
      latched_in = latched_ff;
      sev        = '0;
      for (int k = 0; k < NS; k++) begin
         now_on[k]    = 1'b0;
         slot_used[k] = 1'b0;
         case (modes_ff[k*pvadc_pkg::SLOT_W +: 3]) inside
            pvadc_pkg::SLOT_HIGH, pvadc_pkg::SLOT_HIGH_HIGH: begin
               slot_used[k] = 1'b1;
               now_on[k]    = (pv_ext > trip_ext[k]) || (latched_ff[k] && (pv_ext > thr_ff[k]));
            end
            pvadc_pkg::SLOT_LOW, pvadc_pkg::SLOT_LOW_LOW: begin
               slot_used[k] = 1'b1;
               now_on[k]    = (pv_ext < trip_ext[k]) || (latched_ff[k] && (pv_ext < thr_ff[k]));
            end
            default: ;
         endcase
         active[k]  = slot_used[k] && now_on[k];
         raised[k]  = slot_used[k] && now_on[k] && !latched_ff[k];
         cleared[k] = slot_used[k] && !now_on[k] && latched_ff[k];
         if (slot_used[k]) begin
            latched_in[k] = now_on[k];
         end
         if (active[k]) begin
            sev = {1'b0, modes_ff[k*pvadc_pkg::SLOT_W + 3 +: pvadc_pkg::PRIO_W]} + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= '0;
      end else if (cmd.accept) begin
         latched_ff <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsp_pv_clamped   <= pv_clamped;
         rsp_severity     <= sev;
         rsp_active_mask  <= active;
         rsp_raised_mask  <= raised;
         rsp_cleared_mask <= cleared;
      end
   end

endmodule : pvadc_dp

`default_nettype wire

FILE: test/tb_pv_alarm_deadband_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_pv_alarm_deadband_checker
// Self-checking bench for the process-value alarm checker. Sample beats and
// register writes are fed from one queue, so that writes only happen once the
// checker has drained. Every accepted sample is run through a local model of
// the clamp and the hysteresis latches. Each result beat is compared with the
// oldest prediction, field by field. Sender bursts and receiver stalls vary
// over the run.
//------------------------------------------------------------------------------

module tb_pv_alarm_deadband_checker;

   localparam int     DATA_W         = pvadc_pkg::DATA_W;
   localparam int     SEV_W          = pvadc_pkg::SEV_W;
   localparam int     NUM_SLOTS      = pvadc_pkg::NUM_SLOTS;
   localparam int     SLOT_W         = pvadc_pkg::SLOT_W;
   localparam int     PCT_W          = pvadc_pkg::PCT_W;
   localparam int     MODES_W        = pvadc_pkg::MODES_W;
   localparam int     TRIP_REG_W     = pvadc_pkg::TRIP_REG_W;
   localparam int     NUM_TRIP_REGS  = pvadc_pkg::NUM_TRIP_REGS;
   localparam int     TOTAL_SAMPLES  = 1650;
   localparam int     WATCHDOG_LIMIT = 1000;
   localparam int     SETTLE_CYCLES  = 20;
   localparam int     STALL_RUN_MAX  = 12;
   localparam longint PCT_FULL_SCALE = 25600;
   localparam longint PV_MIN         = -64'sd2147483648;
   localparam longint PV_MAX         = 64'sd2147483647;
   localparam logic [2:0] SLOT_RSVD_5 = 3'd5;
   localparam logic [2:0] SLOT_RSVD_7 = 3'd7;

   typedef enum logic [1:0] {FEED_SAMPLE, FEED_CSR_WRITE, FEED_DRAIN} feed_kind_type;

   typedef struct {
      feed_kind_type            kind;
      pvadc_pkg::csr_index_type idx;
      logic [TRIP_REG_W-1:0]    data;
      logic [DATA_W-1:0]        pv;
   } feed_type;

   typedef struct {
      logic [DATA_W-1:0]    pv_clamped;
      logic [SEV_W-1:0]     severity;
      logic [NUM_SLOTS-1:0] active;
      logic [NUM_SLOTS-1:0] raised;
      logic [NUM_SLOTS-1:0] cleared;
   } alarm_report_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [DATA_W-1:0]    req_pv_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]    rsp_pv_clamped;
   logic [SEV_W-1:0]            rsp_severity;
   logic [NUM_SLOTS-1:0]        rsp_active_mask;
   logic [NUM_SLOTS-1:0]        rsp_raised_mask;
   logic [NUM_SLOTS-1:0]        rsp_cleared_mask;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   pvadc_pkg::csr_index_type    csr_index = pvadc_pkg::CSR_RANGE_LOW;
   logic [TRIP_REG_W-1:0]       csr_wdata = '0;

   feed_type         pending_feed[$];
   alarm_report_type predicted_reports[$];
   feed_type         cur_feed;
   bit               feed_live = 1'b0;
   int               burst_left = 0;
   int               gap_left = 0;
   bit               req_beat = 1'b0;
   bit               csr_beat = 1'b0;
   bit               rsp_beat = 1'b0;
   int               idle_cycles = 0;
   int               mismatches = 0;
   int               samples_queued = 0;

   int            stall_mode = 0;
   int            stall_left = 0;
   int            stall_run = 0;
   logic [2:0]    stall_tick = '0;

   // Model copy of the register file and the slot latches.
   logic signed [DATA_W-1:0] cfg_range_low = '0;
   logic signed [DATA_W-1:0] cfg_range_high = 32'sd6553600;
   logic [PCT_W-1:0]         cfg_deadband = '0;
   logic [MODES_W-1:0]       cfg_slot_modes = '0;
   logic [TRIP_REG_W-1:0]    cfg_trips[NUM_TRIP_REGS];
   logic [NUM_SLOTS-1:0]     alarm_latch = '0;

   // Stimulus-side view of the configuration, used only to aim samples and trip values.
   longint                   g_lo = 0;
   longint                   g_hi = 6553600;
   longint                   g_delta = 0;
   longint                   g_walk = 0;
   logic [PCT_W-1:0]         g_pct = '0;
   logic [TRIP_REG_W-1:0]    g_trip_regs[NUM_TRIP_REGS];

   pv_alarm_deadband_checker uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pv_sample    (req_pv_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pv_clamped   (rsp_pv_clamped),
      .rsp_severity     (rsp_severity),
      .rsp_active_mask  (rsp_active_mask),
      .rsp_raised_mask  (rsp_raised_mask),
      .rsp_cleared_mask (rsp_cleared_mask),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5ns clock = ~clock;

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic alarm_report_type evaluate_alarms(logic [DATA_W-1:0] sample);
      alarm_report_type         r;
      longint                   lo, hi, pv, pct, delta, trip;
      logic [SLOT_W-1:0]        word;
      logic [2:0]               kind;
      logic signed [DATA_W-1:0] trip_word;
      logic                     was, now;
      lo = cfg_range_low;
      hi = cfg_range_high;
      pv = $signed(sample);
      pct = cfg_deadband;
      if (hi > lo) begin
         if (pv > hi) pv = hi;
         if (pv < lo) pv = lo;
      end
      delta = ((hi - lo) * pct) / PCT_FULL_SCALE;
      r.severity = '0;
      r.active = '0;
      r.raised = '0;
      r.cleared = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         word = cfg_slot_modes[i*SLOT_W +: SLOT_W];
         kind = word[2:0];
         trip_word = cfg_trips[i / 2][(i % 2) * DATA_W +: DATA_W];
         trip = trip_word;
         was = alarm_latch[i];
         if (kind == pvadc_pkg::SLOT_HIGH || kind == pvadc_pkg::SLOT_HIGH_HIGH) begin
            now = (pv > trip) || (was && pv > trip - delta);
         end else if (kind == pvadc_pkg::SLOT_LOW || kind == pvadc_pkg::SLOT_LOW_LOW) begin
            now = (pv < trip) || (was && pv < trip + delta);
         end else begin
            continue;
         end
         r.raised[i] = now && !was;
         r.cleared[i] = was && !now;
         r.active[i] = now;
         alarm_latch[i] = now;
         if (now) r.severity = {1'b0, word[6:3]} + 5'd1;
      end
      r.pv_clamped = pv[DATA_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
   endtask

   task automatic check_report(alarm_report_type want);
      if (rsp_pv_clamped !== want.pv_clamped)
         report_mismatch("pv_clamped", want.pv_clamped, rsp_pv_clamped);
      if (rsp_severity !== want.severity)
         report_mismatch("severity", DATA_W'(want.severity), DATA_W'(rsp_severity));
      if (rsp_active_mask !== want.active)
         report_mismatch("active_mask", DATA_W'(want.active), DATA_W'(rsp_active_mask));
      if (rsp_raised_mask !== want.raised)
         report_mismatch("raised_mask", DATA_W'(want.raised), DATA_W'(rsp_raised_mask));
      if (rsp_cleared_mask !== want.cleared)
         report_mismatch("cleared_mask", DATA_W'(want.cleared), DATA_W'(rsp_cleared_mask));
   endtask

   // Handshakes are sampled here, before the checker's own flops settle.
   always @(posedge clock) begin
      req_beat = req_valid && !req_stall;
      csr_beat = csr_valid && csr_ready;
      rsp_beat = rsp_valid && !rsp_stall;
      if (reset) begin
         cfg_range_low = '0;
         cfg_range_high = 32'sd6553600;
         cfg_deadband = '0;
         cfg_slot_modes = '0;
         for (int k = 0; k < NUM_TRIP_REGS; k++) cfg_trips[k] = '0;
         alarm_latch = '0;
         idle_cycles = 0;
      end else begin
         if (rsp_beat) begin
            if (predicted_reports.size() == 0) begin
               $display("%0t: result beat with no sample outstanding, got pv_clamped %h",
                        $time, rsp_pv_clamped);
               mismatches++;
            end else begin
               check_report(predicted_reports.pop_front());
            end
         end
         if (csr_beat) begin
            case (csr_index)
               pvadc_pkg::CSR_RANGE_LOW:  cfg_range_low = csr_wdata[DATA_W-1:0];
               pvadc_pkg::CSR_RANGE_HIGH: cfg_range_high = csr_wdata[DATA_W-1:0];
               pvadc_pkg::CSR_DEADBAND:   cfg_deadband = csr_wdata[PCT_W-1:0];
               pvadc_pkg::CSR_SLOT_MODES: cfg_slot_modes = csr_wdata[MODES_W-1:0];
               default: cfg_trips[csr_index - pvadc_pkg::CSR_TRIPS_0_1] = csr_wdata;
            endcase
         end
         if (req_beat) predicted_reports.push_back(evaluate_alarms(req_pv_sample));
         if (req_beat || csr_beat || rsp_beat) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Register writes and drain markers wait until every prediction has been met.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         feed_live = 1'b0;
      end else begin
         if (feed_live && ((cur_feed.kind == FEED_SAMPLE && req_beat) ||
                           (cur_feed.kind == FEED_CSR_WRITE && csr_beat)))
            feed_live = 1'b0;
         if (!feed_live && pending_feed.size() != 0) begin
            if (pending_feed[0].kind != FEED_SAMPLE) begin
               if (predicted_reports.size() == 0) begin
                  cur_feed = pending_feed.pop_front();
                  feed_live = (cur_feed.kind == FEED_CSR_WRITE);
               end
            end else begin
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                           : $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
               if (gap_left != 0) begin
                  gap_left--;
               end else begin
                  cur_feed = pending_feed.pop_front();
                  feed_live = 1'b1;
                  burst_left--;
               end
            end
         end
         req_valid <= feed_live && cur_feed.kind == FEED_SAMPLE;
         csr_valid <= feed_live && cur_feed.kind == FEED_CSR_WRITE;
         if (feed_live) begin
            req_pv_sample <= cur_feed.pv;
            csr_index <= cur_feed.idx;
            csr_wdata <= cur_feed.data;
         end
      end
   end

   always @(negedge clock) begin
      logic want;
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(50, 400);
      end
      stall_left--;
      stall_tick = stall_tick + 3'd1;
      case (stall_mode)
         0:       want = 1'b0;
         1:       want = ($urandom_range(0, 1) == 0);
         2:       want = ($urandom_range(0, 9) < 8);
         default: want = (stall_tick >= 3'd5);
      endcase
      if (want && stall_run >= STALL_RUN_MAX) want = 1'b0;
      stall_run = want ? stall_run + 1 : 0;
      rsp_stall <= want;
   end

   function automatic logic [DATA_W-1:0] q16(int units);
      return units * 65536;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_word(logic [2:0] kind, logic [3:0] prio);
      return {prio, kind};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic longint rand_in(longint lo_v, longint hi_v);
      logic [63:0] r;
      r = rand64();
      return lo_v + longint'(r % (hi_v - lo_v + 1));
   endfunction

   function automatic logic [DATA_W-1:0] sat32(longint v);
      if (v > PV_MAX) return PV_MAX[DATA_W-1:0];
      if (v < PV_MIN) return PV_MIN[DATA_W-1:0];
      return v[DATA_W-1:0];
   endfunction

   function automatic longint trip_of(int slot);
      logic signed [DATA_W-1:0] w;
      w = g_trip_regs[slot / 2][(slot % 2) * DATA_W +: DATA_W];
      return w;
   endfunction

   task automatic push_sample(logic [DATA_W-1:0] pv);
      feed_type f;
      f.kind = FEED_SAMPLE;
      f.idx = pvadc_pkg::CSR_RANGE_LOW;
      f.data = '0;
      f.pv = pv;
      pending_feed.push_back(f);
      samples_queued++;
   endtask

   task automatic push_drain();
      feed_type f;
      f.kind = FEED_DRAIN;
      f.idx = pvadc_pkg::CSR_RANGE_LOW;
      f.data = '0;
      f.pv = '0;
      pending_feed.push_back(f);
   endtask

   task automatic push_csr(pvadc_pkg::csr_index_type idx, logic [63:0] data);
      feed_type f;
      f.kind = FEED_CSR_WRITE;
      f.idx = idx;
      f.data = data;
      f.pv = '0;
      pending_feed.push_back(f);
      case (idx)
         pvadc_pkg::CSR_RANGE_LOW:  g_lo = $signed(data[DATA_W-1:0]);
         pvadc_pkg::CSR_RANGE_HIGH: g_hi = $signed(data[DATA_W-1:0]);
         pvadc_pkg::CSR_DEADBAND:   g_pct = data[PCT_W-1:0];
         pvadc_pkg::CSR_SLOT_MODES: ;
         default:                   g_trip_regs[idx - pvadc_pkg::CSR_TRIPS_0_1] = data;
      endcase
      g_delta = ((g_hi - g_lo) * longint'(g_pct)) / PCT_FULL_SCALE;
   endtask

   function automatic logic [DATA_W-1:0] pick_sample();
      longint span, m, off;
      span = (g_hi > g_lo) ? g_hi - g_lo : (64'sd1 << 24);
      case ($urandom_range(0, 19))
         0, 1: return $urandom();
         2: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               4: return sat32(g_lo);
               default: return sat32(g_hi);
            endcase
         end
         3, 4, 5, 6, 7, 8: begin
            case ($urandom_range(0, 8))
               0: off = -g_delta - 1;
               1: off = -g_delta;
               2: off = -g_delta + 1;
               3: off = -1;
               4: off = 0;
               5: off = 1;
               6: off = g_delta - 1;
               7: off = g_delta;
               default: off = g_delta + 1;
            endcase
            g_walk = trip_of($urandom_range(0, NUM_SLOTS - 1)) + off;
         end
         default: begin
            m = span / 12 + 1;
            g_walk = g_walk + rand_in(-m, m);
            if (g_hi > g_lo) begin
               if (g_walk > g_hi + span / 8) g_walk = g_hi;
               if (g_walk < g_lo - span / 8) g_walk = g_lo;
            end
         end
      endcase
      g_walk = $signed(sat32(g_walk));
      return g_walk[DATA_W-1:0];
   endfunction

   task automatic new_setup();
      longint             lo, hi, a, b, trip;
      logic [MODES_W-1:0] modes;
      logic [63:0]        r;
      logic [PCT_W-1:0]   pct;
      logic [2:0]         kind;
      bit                 force_range;
      force_range = 1'b1;
      case ($urandom_range(0, 9))
         0: begin
            lo = PV_MIN;
            hi = PV_MAX;
         end
         1: begin
            lo = rand_in(PV_MIN, PV_MAX);
            hi = lo;
         end
         2: begin
            a = rand_in(PV_MIN, PV_MAX);
            b = rand_in(PV_MIN, PV_MAX);
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
         end
         default: begin
            a = rand_in(-(64'sd1 << 30), 64'sd1 << 30);
            b = rand_in(64'sd1 << 12, 64'sd1 << 27);
            lo = a - b;
            hi = a + b;
            force_range = 1'b0;
         end
      endcase
      if (force_range || $urandom_range(0, 3) != 0)
         push_csr(pvadc_pkg::CSR_RANGE_LOW, {$urandom(), lo[DATA_W-1:0]});
      if (force_range || $urandom_range(0, 3) != 0)
         push_csr(pvadc_pkg::CSR_RANGE_HIGH, {$urandom(), hi[DATA_W-1:0]});
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 7))
            0:       pct = '0;
            1:       pct = 15'd25600;
            2:       pct = '1;
            default: pct = PCT_W'($urandom_range(0, 5120));
         endcase
         r = rand64();
         push_csr(pvadc_pkg::CSR_DEADBAND, {r[63:PCT_W], pct});
      end
      if ($urandom_range(0, 1) == 0) begin
         if ($urandom_range(0, 5) == 0) begin
            r = rand64();
            modes = r[MODES_W-1:0];
         end else begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               kind = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 4));
               modes[s*SLOT_W +: SLOT_W] = slot_word(kind, 4'($urandom_range(0, 15)));
            end
         end
         r = rand64();
         push_csr(pvadc_pkg::CSR_SLOT_MODES, {r[63:MODES_W], modes});
      end
      for (int k = 0; k < NUM_TRIP_REGS; k++) begin
         if ($urandom_range(0, 1) == 0) begin
            for (int h = 0; h < 2; h++) begin
               if ($urandom_range(0, 7) == 0) trip = $signed($urandom());
               else if (g_hi > g_lo) trip = rand_in(g_lo, g_hi);
               else trip = g_lo + rand_in(-(64'sd1 << 20), 64'sd1 << 20);
               r[h*DATA_W +: DATA_W] = sat32(trip);
            end
            push_csr(pvadc_pkg::csr_index_type'(pvadc_pkg::CSR_TRIPS_0_1 + k), r);
         end
      end
   endtask

   initial begin
      int phase_len;
      for (int k = 0; k < NUM_TRIP_REGS; k++) g_trip_regs[k] = '0;

      // Reset settings: clamping into 0 .. 100 with no slots in use.
      push_sample(32'h8000_0000);
      push_sample(32'h7FFF_FFFF);
      push_sample(32'h0000_0000);

      // Range -100 .. 100 with a 10 % deadband, i.e. 20.0 of hysteresis.
      push_csr(pvadc_pkg::CSR_RANGE_LOW, {32'hDEAD_BEEF, q16(-100)});
      push_csr(pvadc_pkg::CSR_RANGE_HIGH, {32'h1234_5678, q16(100)});
      push_csr(pvadc_pkg::CSR_DEADBAND, 64'hA5A5_A5A5_A5A5_8000 | 64'd2560);
      push_csr(pvadc_pkg::CSR_SLOT_MODES, {8'hC3,
               slot_word(pvadc_pkg::SLOT_HIGH, 4'd15), slot_word(SLOT_RSVD_7, 4'd1),
               slot_word(SLOT_RSVD_5, 4'd5), slot_word(pvadc_pkg::SLOT_NONE, 4'd7),
               slot_word(pvadc_pkg::SLOT_LOW_LOW, 4'd4), slot_word(pvadc_pkg::SLOT_LOW, 4'd2),
               slot_word(pvadc_pkg::SLOT_HIGH_HIGH, 4'd9),
               slot_word(pvadc_pkg::SLOT_HIGH, 4'd3)});
      push_csr(pvadc_pkg::CSR_TRIPS_0_1, {q16(80), q16(50)});
      push_csr(pvadc_pkg::CSR_TRIPS_2_3, {q16(-80), q16(-50)});
      push_csr(pvadc_pkg::CSR_TRIPS_4_5, {q16(0), q16(0)});
      push_csr(pvadc_pkg::CSR_TRIPS_6_7, {q16(90), q16(0)});
      push_sample(q16(60));
      push_sample(q16(45));
      push_sample(q16(30));
      push_sample(q16(85));
      push_sample(q16(95));
      push_sample(q16(200));
      push_drain();
      push_sample(q16(100));
      push_sample(q16(-60));
      push_sample(q16(-45));
      push_sample(q16(-30));
      push_sample(q16(-90));
      push_sample(q16(-200));
      push_sample(q16(0));

      // Inverted range: no clamping and a negative deadband.
      push_csr(pvadc_pkg::CSR_RANGE_LOW, {32'h0, q16(10)});
      push_csr(pvadc_pkg::CSR_RANGE_HIGH, {32'h0, q16(-10)});
      push_csr(pvadc_pkg::CSR_DEADBAND, 64'd25600);
      push_sample(32'h7FFF_FFFF);
      push_sample(q16(65));
      push_sample(32'h8000_0000);

      // Empty range: the deadband collapses to zero.
      push_csr(pvadc_pkg::CSR_RANGE_HIGH, {32'hFFFF_FFFF, q16(10)});
      push_sample(q16(50));

      g_walk = 0;
      while (samples_queued < TOTAL_SAMPLES) begin
         new_setup();
         phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                 : $urandom_range(10, 80);
         for (int n = 0; n < phase_len; n++) begin
            if ($urandom_range(0, 199) == 0) push_drain();
            push_sample(pick_sample());
         end
      end

      wait (!reset);
      while (pending_feed.size() != 0 || feed_live || predicted_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
